@@ rtl/core/bte_pkg.sv @@
package bte_pkg;

   localparam logic [7:0] TopMask  = 8'hC0;
   localparam logic [6:0] PairMark = 7'h70;
   localparam logic [6:0] OneMark  = 7'h60;
   localparam logic [6:0] CharBias = 7'h20;
   localparam int         MaxChars = 3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_word_type;

   typedef struct packed {
      logic [6:0] enc_char;
      logic       run_last;
      logic       stream_end;
   } rsp_word_type;

   typedef logic [1:0] char_count_type;

   function automatic logic [6:0] bias_low(input logic [7:0] value);
      return {1'b0, value[5:0]} + CharBias;
   endfunction

endpackage

@@ rtl/core/bte_if.sv @@
interface bte_req_if;
   import bte_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface bte_rsp_if;
   import bte_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

@@ rtl/core/binary_to_text_encoder_core.sv @@
// The first character of a word is offered in the cycle after the word is accepted.
// One character per cycle while the receiver is ready; a word produces 1 to 3 characters,
// or none when its byte is only held; the one-character result channel sets the rate.
// A new word is taken in the cycle the last pending character leaves.
// Reset (synchronous, active high) clears the held byte and drops any pending characters.
module binary_to_text_encoder_core (
   input  logic      clock,
   input  logic      reset,
   bte_req_if.sink   req_ch,
   bte_rsp_if.source rsp_ch
);
   import bte_pkg::*;

   logic [7:0]     held_byte_ff, held_byte_in;
   logic           held_valid_ff, held_valid_in;
   logic [6:0]     char_ff [MaxChars], char_in [MaxChars];
   logic           eod_ff, eod_in;
   char_count_type count_ff, count_in;
   char_count_type idx_ff, idx_in;

   logic           req_take, rsp_take, job_done, has_top;
   char_count_type new_count;
   logic [6:0]     new_char [MaxChars];

   assign rsp_take = rsp_ch.valid && rsp_ch.ready;
   assign job_done = rsp_take && (idx_ff == count_ff - 2'd1);
   assign req_ch.ready = (count_ff == 2'd0) || job_done;
   assign req_take = req_ch.valid && req_ch.ready;
   assign has_top = (req_ch.word.data_byte & TopMask) != 8'h00;

   always_comb begin
      new_char[0]   = bias_low(req_ch.word.data_byte);
      new_char[1]   = 7'h00;
      new_char[2]   = 7'h00;
      new_count     = 2'd1;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      if (held_valid_ff) begin
         if (has_top) begin
            new_char[0] = PairMark | {3'b000, req_ch.word.data_byte[7:6], held_byte_ff[7:6]};
         end else begin
            new_char[0] = OneMark | {5'b00000, held_byte_ff[7:6]};
         end
         new_char[1]   = bias_low(held_byte_ff);
         new_char[2]   = bias_low(req_ch.word.data_byte);
         new_count     = 2'd3;
         held_valid_in = 1'b0;
         held_byte_in  = 8'h00;
      end else if (has_top) begin
         if (req_ch.word.end_of_data) begin
            new_char[0] = OneMark | {5'b00000, req_ch.word.data_byte[7:6]};
            new_char[1] = bias_low(req_ch.word.data_byte);
            new_count   = 2'd2;
         end else begin
            new_count     = 2'd0;
            held_valid_in = 1'b1;
            held_byte_in  = req_ch.word.data_byte;
         end
      end
      if (!req_take) begin
         held_byte_in  = held_byte_ff;
         held_valid_in = held_valid_ff;
      end
   end

   always_comb begin
      char_in  = char_ff;
      eod_in   = eod_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      if (req_take) begin
         char_in  = new_char;
         eod_in   = req_ch.word.end_of_data;
         count_in = new_count;
         idx_in   = 2'd0;
      end else if (job_done) begin
         count_in = 2'd0;
         idx_in   = 2'd0;
      end else if (rsp_take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_byte_ff  <= 8'h00;
         count_ff      <= 2'd0;
         idx_ff        <= 2'd0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      eod_ff  <= eod_in;
   end

   assign rsp_ch.valid           = count_ff != 2'd0;
   assign rsp_ch.word.enc_char   = char_ff[idx_ff];
   assign rsp_ch.word.run_last   = idx_ff == count_ff - 2'd1;
   assign rsp_ch.word.stream_end = (idx_ff == count_ff - 2'd1) && eod_ff;

endmodule

@@ tb/tb_binary_to_text_encoder_core.sv @@
module tb_binary_to_text_encoder_core;
   import bte_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int ReportLimit = 10;

   typedef struct {
      req_word_type word;
      bit           drain_first;
   } pending_word_type;

   logic clock;
   logic reset;

   bte_req_if req_ch ();
   bte_rsp_if rsp_ch ();

   binary_to_text_encoder_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   pending_word_type pending_words[$];
   rsp_word_type     expected_chars[$];

   logic [7:0] held_byte;
   logic       held_valid;

   int   error_count;
   int   cycle_count;
   bit   word_taken;
   int   burst_left;
   int   gap_left;
   int   stall_phase;
   logic [15:0] stall_pattern;

   function automatic void push_char(input logic [6:0] ch, input logic last,
                                     input logic fin);
      rsp_word_type c;
      c.enc_char   = ch;
      c.run_last   = last;
      c.stream_end = fin;
      expected_chars.push_back(c);
   endfunction

   function automatic void encode_byte(input req_word_type w);
      logic [7:0] b;
      logic [6:0] lead;
      logic [6:0] tail;
      b = w.data_byte;
      if (held_valid) begin
         if ((b & TopMask) != 8'h00) begin
            lead = PairMark | {3'b000, b[7:6], held_byte[7:6]};
            tail = {1'b0, b[5:0]} + CharBias;
         end else begin
            lead = OneMark | {5'b00000, held_byte[7:6]};
            tail = b[6:0] + CharBias;
         end
         push_char(lead, 1'b0, 1'b0);
         push_char({1'b0, held_byte[5:0]} + CharBias, 1'b0, 1'b0);
         push_char(tail, 1'b1, w.end_of_data);
         held_valid = 1'b0;
         held_byte  = 8'h00;
      end else if ((b & TopMask) != 8'h00) begin
         if (w.end_of_data) begin
            push_char(OneMark | {5'b00000, b[7:6]}, 1'b0, 1'b0);
            push_char({1'b0, b[5:0]} + CharBias, 1'b1, 1'b1);
         end else begin
            held_byte  = b;
            held_valid = 1'b1;
         end
      end else begin
         push_char(b[6:0] + CharBias, 1'b1, w.end_of_data);
      end
   endfunction

   function automatic void add_word(input logic [7:0] b, input logic eod,
                                    input bit drain);
      pending_word_type p;
      p.word.data_byte   = b;
      p.word.end_of_data = eod;
      p.drain_first      = drain;
      pending_words.push_back(p);
   endfunction

   function automatic logic [7:0] random_byte();
      logic [7:0] b;
      case ($urandom_range(0, 2))
         0: b = 8'($urandom_range(0, 63));
         1: b = 8'($urandom_range(64, 255));
         default: b = 8'($urandom);
      endcase
      return b;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // driver: bursts with gaps, optional drain hold-off
   always @(negedge clock) begin
      logic         next_valid;
      req_word_type next_word;
      next_valid = req_ch.valid;
      next_word  = req_ch.word;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!(req_ch.valid && !word_taken)) begin
         next_valid = 1'b0;
         if (pending_words.size() != 0 && pending_words[0].drain_first &&
             expected_chars.size() != 0) begin
            next_valid = 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (pending_words.size() != 0) begin
            next_word  = pending_words.pop_front().word;
            next_valid = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_ch.valid <= next_valid;
      req_ch.word  <= next_word;
   end

   // receiver: rotating stall pattern, re-chosen each time stall_phase wraps to zero
   always @(negedge clock) begin
      if (stall_phase == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pattern = 16'hFFFF;
            1: stall_pattern = 16'($urandom) | 16'h0001;
            2: stall_pattern = 16'($urandom | $urandom) | 16'h0001;
            default: stall_pattern = 16'h0001 << $urandom_range(0, 3);
         endcase
      end
      stall_phase = (stall_phase + 1) % 64;
      rsp_ch.ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type exp_c;
      rsp_word_type got_c;
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("binary_to_text_encoder_core regression: fail");
         $finish;
      end
      word_taken = !reset && req_ch.valid && req_ch.ready;
      if (word_taken)
         encode_byte(req_ch.word);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_c = rsp_ch.word;
         if (expected_chars.size() == 0) begin
            error_count++;
            if (error_count <= ReportLimit)
               $display("unexpected word: char=%h last=%b end=%b",
                        got_c.enc_char, got_c.run_last, got_c.stream_end);
         end else begin
            exp_c = expected_chars.pop_front();
            if (got_c.enc_char !== exp_c.enc_char || got_c.run_last !== exp_c.run_last ||
                got_c.stream_end !== exp_c.stream_end) begin
               error_count++;
               if (error_count <= ReportLimit)
                  $display("mismatch: exp char=%h last=%b end=%b, got char=%h last=%b end=%b",
                           exp_c.enc_char, exp_c.run_last, exp_c.stream_end,
                           got_c.enc_char, got_c.run_last, got_c.stream_end);
            end
         end
      end
   end

   initial begin
      int         n;
      int         len;
      logic [7:0] b;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.word  = '0;
      rsp_ch.ready = 1'b0;
      held_byte    = 8'h00;
      held_valid   = 1'b0;
      error_count  = 0;
      cycle_count  = 0;
      word_taken   = 1'b0;
      burst_left   = 1;
      gap_left     = 0;
      stall_phase  = 0;
      stall_pattern = 16'hFFFF;

      // directed
      add_word(8'h00, 1'b0, 1'b0);
      add_word(8'h3F, 1'b0, 1'b0);
      add_word(8'h3F, 1'b1, 1'b0);
      add_word(8'h00, 1'b1, 1'b0);
      add_word(8'h40, 1'b1, 1'b0);
      add_word(8'hFF, 1'b1, 1'b0);
      add_word(8'h80, 1'b1, 1'b0);
      add_word(8'hC0, 1'b0, 1'b0);
      add_word(8'h00, 1'b0, 1'b0);
      add_word(8'h41, 1'b0, 1'b0);
      add_word(8'h3F, 1'b1, 1'b0);
      add_word(8'hFF, 1'b0, 1'b1);
      add_word(8'hFF, 1'b0, 1'b0);
      add_word(8'h40, 1'b0, 1'b0);
      add_word(8'h80, 1'b1, 1'b0);
      add_word(8'h80, 1'b0, 1'b0);
      add_word(8'hC0, 1'b0, 1'b0);
      add_word(8'hBF, 1'b0, 1'b0);
      add_word(8'h7F, 1'b1, 1'b0);
      add_word(8'h2A, 1'b0, 1'b1);
      add_word(8'hD5, 1'b0, 1'b0);
      add_word(8'h15, 1'b1, 1'b0);

      // random streams, each ending on end of data
      n = 0;
      while (n < 350) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            b = random_byte();
            add_word(b, (i == len - 1) ? 1'b1 : 1'($urandom_range(0, 15) == 0),
                     $urandom_range(0, 39) == 0);
            n++;
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_words.size() != 0 || req_ch.valid) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("binary_to_text_encoder_core regression: pass");
      end else begin
         $display("binary_to_text_encoder_core regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/bte_pkg.sv
rtl/core/bte_if.sv
rtl/core/binary_to_text_encoder_core.sv
tb/tb_binary_to_text_encoder_core.sv
